// ===== hw/rtl/tccs_pkg.sv =====
// Package for the text console with cursor and scroll.
// Field widths, character and command codes, register map and reset defaults.
// No dependencies.
package tccs_pkg;

    // Port field widths
    localparam int MODE_W = 2;
    localparam int CHAR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CLR_W  = 4;
    localparam int CELL_W = CHAR_W + 2 * CLR_W;

    // Default geometry
    localparam int DEF_COLUMNS  = 80;
    localparam int DEF_ROWS     = 25;
    localparam int DEF_TAB_STOP = 8;

    // Command modes
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

    // APB register map: register index sits at paddr[2]
    localparam int   PADDR_W  = 3;
    localparam int   PDATA_W  = 32;
    localparam int   REG_BIT  = 2;
    localparam logic REG_FG   = 1'b0;
    localparam logic REG_BG   = 1'b1;

    localparam logic [CLR_W-1:0] FG_RESET = 4'd15;
    localparam logic [CLR_W-1:0] BG_RESET = 4'd1;

    // Cell layout: bg in [15:12], fg in [11:8], char in [7:0]
    function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                    input logic [CLR_W-1:0]  fg,
                                                    input logic [CLR_W-1:0]  bg);
        return {bg, fg, ch};
    endfunction

endpackage

// ===== hw/rtl/text_console_cursor_scroll.sv =====
// Text console top level: screen store, cursor logic, scroll/clear sweeper, APB registers.
// Depends on tccs_pkg.
//
// A command is taken when start is high and busy is low. Every command
// returns exactly one result, shown on the o_ result ports for a single cycle
// with o_done high; the receiver cannot stall, so it must capture it then.
// Put-character, read-cell and unused-mode commands are captured, then make one
// pass through the memory, so such commands can follow back to back. All screen
// traffic goes through one cell memory with one write port and one registered
// read port (one write, one registered read per cycle), which sets the cost of
// the bulk operations:
//   clear screen : one blank write per cell
//   scroll       : a read then a write for each of the COLUMNS*(ROWS-1) moved
//                  cells, then one blank write per bottom-row cell
// After reset the block runs a clearing pass over all COLUMNS*ROWS cells with
// busy high; APB register transfers are taken throughout.
// Config registers (foreground color at 0x0, background color at 0x4) should
// only be written while no command is in flight.
module text_console_cursor_scroll #(
    parameter int COLUMNS  = tccs_pkg::DEF_COLUMNS,
    parameter int ROWS     = tccs_pkg::DEF_ROWS,
    parameter int TAB_STOP = tccs_pkg::DEF_TAB_STOP
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [tccs_pkg::MODE_W-1:0]   i_mode,
    input  logic [tccs_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tccs_pkg::COL_W-1:0]    i_read_col,
    input  logic [tccs_pkg::ROW_W-1:0]    i_read_row,
    // result channel
    output logic                          o_done,
    output logic [tccs_pkg::CHAR_W-1:0]   o_cell_char,
    output logic [tccs_pkg::CLR_W-1:0]    o_cell_fg,
    output logic [tccs_pkg::CLR_W-1:0]    o_cell_bg,
    output logic [tccs_pkg::COL_W-1:0]    o_cursor_col,
    output logic [tccs_pkg::ROW_W-1:0]    o_cursor_row,
    output logic                          o_scrolled,
    // APB config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tccs_pkg::PADDR_W-1:0]  paddr,
    input  logic [tccs_pkg::PDATA_W-1:0]  pwdata,
    output logic [tccs_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import tccs_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(COLUMNS);             // stored column
    localparam int XE    = $clog2(COLUMNS + TAB_STOP);  // column before wrap
    localparam int YW    = $clog2(ROWS);                // stored row
    localparam int YE    = $clog2(ROWS + 1);            // row before scroll
    localparam int MW    = $clog2(TAB_STOP);            // column mod tab stop

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_FILL
    } t_state;

    // Screen store
    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rdata;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;

    // Control and payload registers
    t_state              r_state, n_state;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic                r_init, n_init;       // reset clearing pass, no result
    logic                r_scr, n_scr;
    logic [CELL_W-1:0]   r_blank, n_blank;
    logic [XW-1:0]       r_cx, n_cx;
    logic [YW-1:0]       r_cy, n_cy;
    logic [MW-1:0]       r_xmod, n_xmod;       // tracks cursor column mod TAB_STOP
    logic [CLR_W-1:0]    r_fg, n_fg;
    logic [CLR_W-1:0]    r_bg, n_bg;
    logic [MODE_W-1:0]   r_mode, n_mode;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic                r_rd_ok, n_rd_ok;

    // Result registers
    logic                r_done, n_done;
    logic [CHAR_W-1:0]   r_out_char, n_out_char;
    logic [CLR_W-1:0]    r_out_fg, n_out_fg;
    logic [CLR_W-1:0]    r_out_bg, n_out_bg;
    logic [COL_W-1:0]    r_out_col, n_out_col;
    logic [ROW_W-1:0]    r_out_row, n_out_row;
    logic                r_out_scr, n_out_scr;

    logic                accept;
    logic                cfg_wr;
    logic                in_range;
    logic [AW-1:0]       in_addr;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Register readback
    assign prdata = (paddr[REG_BIT] == REG_BG) ? PDATA_W'(r_bg) : PDATA_W'(r_fg);

    // Read-cell address straight from the command ports, so data is ready in EXEC
    assign in_range = (int'(i_read_col) < COLUMNS) && (int'(i_read_row) < ROWS);
    assign in_addr  = in_range ? (AW'(i_read_row) * AW'(COLUMNS) + AW'(i_read_col))
                               : '0;

    assign mem_raddr = (r_state == ST_SCR_RD) ? (r_ptr + AW'(COLUMNS)) : in_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_comb begin
        logic [XE-1:0] nx;
        logic [YE-1:0] ny;
        logic [MW-1:0] nm;
        logic [XW-1:0] wcol;
        logic          wr_cell;
        logic [CHAR_W-1:0] wch;

        n_state    = r_state;
        n_ptr      = r_ptr;
        n_init     = r_init;
        n_scr      = r_scr;
        n_blank    = r_blank;
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_xmod     = r_xmod;
        n_fg       = r_fg;
        n_bg       = r_bg;
        n_mode     = r_mode;
        n_char     = r_char;
        n_rd_ok    = r_rd_ok;
        n_done     = 1'b0;
        n_out_char = r_out_char;
        n_out_fg   = r_out_fg;
        n_out_bg   = r_out_bg;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_out_scr  = r_out_scr;

        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = r_blank;

        nx      = XE'(r_cx);
        ny      = YE'(r_cy);
        nm      = r_xmod;
        wcol    = r_cx;
        wr_cell = 1'b0;
        wch     = CH_SPACE;

        if (cfg_wr) begin
            if (paddr[REG_BIT] == REG_BG) begin
                n_bg = pwdata[CLR_W-1:0];
            end else begin
                n_fg = pwdata[CLR_W-1:0];
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_mode  = i_mode;
                    n_char  = i_char_code;
                    n_rd_ok = in_range;
                    n_state = ST_EXEC;
                end
            end

            ST_EXEC: begin
                n_out_char = '0;
                n_out_fg   = '0;
                n_out_bg   = '0;
                n_out_scr  = 1'b0;
                n_state    = ST_IDLE;
                n_blank    = make_cell(CH_SPACE, r_fg, r_bg);

                if (r_mode == MODE_PUT) begin
                    if (r_char == CH_BS) begin
                        if (r_cx != '0) begin
                            nx      = XE'(r_cx) - 1'b1;
                            wcol    = r_cx - 1'b1;
                            wr_cell = 1'b1;
                            nm      = (r_xmod == '0) ? MW'(TAB_STOP - 1) : r_xmod - 1'b1;
                        end
                    end else if (r_char == CH_TAB) begin
                        nx = XE'(r_cx) + XE'(TAB_STOP) - XE'(r_xmod);
                        nm = '0;
                    end else if (r_char == CH_CR) begin
                        nx = '0;
                        nm = '0;
                    end else if (r_char == CH_LF) begin
                        nx = '0;
                        ny = ny + 1'b1;
                        nm = '0;
                    end else if (r_char >= CH_SPACE && r_char <= CH_LAST) begin
                        wch     = r_char;
                        wr_cell = 1'b1;
                        nx      = XE'(r_cx) + 1'b1;
                        nm      = (r_xmod == MW'(TAB_STOP - 1)) ? '0 : r_xmod + 1'b1;
                    end

                    // right-edge wrap
                    if (nx >= XE'(COLUMNS)) begin
                        nx = '0;
                        ny = ny + 1'b1;
                        nm = '0;
                    end

                    mem_we    = wr_cell;
                    mem_waddr = AW'(r_cy) * AW'(COLUMNS) + AW'(wcol);
                    mem_wdata = make_cell(wch, r_fg, r_bg);

                    n_xmod = nm;
                    if (ny == YE'(ROWS)) begin
                        // bottom edge: scroll, cursor to start of last row
                        n_cx    = '0;
                        n_cy    = YW'(ROWS - 1);
                        n_xmod  = '0;
                        n_scr   = 1'b1;
                        n_init  = 1'b0;
                        n_ptr   = '0;
                        n_state = ST_SCR_RD;
                    end else begin
                        n_cx      = XW'(nx);
                        n_cy      = YW'(ny);
                        n_done    = 1'b1;
                        n_out_col = COL_W'(nx);
                        n_out_row = ROW_W'(ny);
                    end
                end else if (r_mode == MODE_CLEAR) begin
                    n_cx    = '0;
                    n_cy    = '0;
                    n_xmod  = '0;
                    n_scr   = 1'b0;
                    n_init  = 1'b0;
                    n_ptr   = '0;
                    n_state = ST_FILL;
                end else begin
                    // read cell, or unused mode
                    n_done    = 1'b1;
                    n_out_col = COL_W'(r_cx);
                    n_out_row = ROW_W'(r_cy);
                    if (r_mode == MODE_READ && r_rd_ok) begin
                        n_out_char = r_rdata[CHAR_W-1:0];
                        n_out_fg   = r_rdata[CHAR_W +: CLR_W];
                        n_out_bg   = r_rdata[CHAR_W+CLR_W +: CLR_W];
                    end
                end
            end

            ST_SCR_RD: begin
                n_state = ST_SCR_WR;
            end

            ST_SCR_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = r_rdata;
                n_ptr     = r_ptr + 1'b1;
                n_state   = (r_ptr == AW'(CELLS - COLUMNS - 1)) ? ST_FILL : ST_SCR_RD;
            end

            ST_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = r_blank;
                n_ptr     = r_ptr + 1'b1;
                if (r_ptr == AW'(CELLS - 1)) begin
                    n_state   = ST_IDLE;
                    n_init    = 1'b0;
                    n_done    = !r_init;
                    n_out_col = COL_W'(r_cx);
                    n_out_row = ROW_W'(r_cy);
                    n_out_scr = r_scr;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FILL;
            r_ptr     <= '0;
            r_init    <= 1'b1;
            r_scr     <= 1'b0;
            r_blank   <= make_cell(CH_SPACE, FG_RESET, BG_RESET);
            r_cx      <= '0;
            r_cy      <= '0;
            r_xmod    <= '0;
            r_fg      <= FG_RESET;
            r_bg      <= BG_RESET;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_init    <= n_init;
            r_scr     <= n_scr;
            r_blank   <= n_blank;
            r_cx      <= n_cx;
            r_cy      <= n_cy;
            r_xmod    <= n_xmod;
            r_fg      <= n_fg;
            r_bg      <= n_bg;
            r_done    <= n_done;
        end
        r_mode     <= n_mode;
        r_char     <= n_char;
        r_rd_ok    <= n_rd_ok;
        r_out_char <= n_out_char;
        r_out_fg   <= n_out_fg;
        r_out_bg   <= n_out_bg;
        r_out_col  <= n_out_col;
        r_out_row  <= n_out_row;
        r_out_scr  <= n_out_scr;
    end

    assign o_done       = r_done;
    assign o_cell_char  = r_out_char;
    assign o_cell_fg    = r_out_fg;
    assign o_cell_bg    = r_out_bg;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_scrolled   = r_out_scr;

endmodule

// ===== tb/text_console_cursor_scroll_tb.sv =====
// Self-checking bench for text_console_cursor_scroll: directed and random commands.
// A shadow of the screen, cursor and colors predicts each result; APB writes set colors.
// Depends on tccs_pkg and the text_console_cursor_scroll RTL.
`timescale 1ns / 1ps

module text_console_cursor_scroll_tb;
    import tccs_pkg::*;

    localparam int SCREEN_COLS = DEF_COLUMNS;
    localparam int SCREEN_ROWS = DEF_ROWS;
    localparam int TAB_WIDTH   = DEF_TAB_STOP;
    localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
    localparam int REPORT_CAP  = 40;

    // mode 3 has no meaning: the block must leave everything alone
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // one result transfer, field by field
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [CLR_W-1:0]  fg;
        logic [CLR_W-1:0]  bg;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              scr;
    } t_answer;

    // Shadow of the console: screen store, cursor and colors, plus the
    // answers still owed by the block in command order.
    class t_screen_shadow;
        logic [CELL_W-1:0] cells [CELL_COUNT];
        int                cur_x;
        int                cur_y;
        logic [CLR_W-1:0]  fg;
        logic [CLR_W-1:0]  bg;
        t_answer           answers_due[$];
        int                faults;

        function new();
            fg     = FG_RESET;
            bg     = BG_RESET;
            faults = 0;
            blank_all();
        endfunction

        function void blank_all();
            for (int i = 0; i < CELL_COUNT; i++) cells[i] = {bg, fg, CH_SPACE};
            cur_x = 0;
            cur_y = 0;
        endfunction

        function void paint(logic [CHAR_W-1:0] c);
            cells[cur_y * SCREEN_COLS + cur_x] = {bg, fg, c};
        endfunction

        // move every row up one, blank the bottom row, park at its start
        function void scroll_up();
            for (int i = 0; i < CELL_COUNT - SCREEN_COLS; i++) cells[i] = cells[i + SCREEN_COLS];
            for (int i = CELL_COUNT - SCREEN_COLS; i < CELL_COUNT; i++)
                cells[i] = {bg, fg, CH_SPACE};
            cur_y = SCREEN_ROWS - 1;
            cur_x = 0;
        endfunction

        function void apply_command(logic [MODE_W-1:0] m, logic [CHAR_W-1:0] c,
                                    logic [COL_W-1:0] rc, logic [ROW_W-1:0] rr);
            t_answer a;
            a = '0;
            case (m)
                MODE_PUT: begin
                    if (c == CH_BS) begin
                        if (cur_x != 0) begin
                            cur_x--;
                            paint(CH_SPACE);
                        end
                    end else if (c == CH_TAB) begin
                        cur_x = cur_x + TAB_WIDTH - (cur_x % TAB_WIDTH);
                    end else if (c == CH_CR) begin
                        cur_x = 0;
                    end else if (c == CH_LF) begin
                        cur_x = 0;
                        cur_y++;
                    end else if (c >= CH_SPACE && c <= CH_LAST) begin
                        paint(c);
                        cur_x++;
                    end
                    if (cur_x >= SCREEN_COLS) begin
                        cur_x = 0;
                        cur_y++;
                    end
                    if (cur_y >= SCREEN_ROWS) begin
                        scroll_up();
                        a.scr = 1'b1;
                    end
                end
                MODE_READ: begin
                    if (rc < SCREEN_COLS && rr < SCREEN_ROWS)
                        {a.bg, a.fg, a.ch} = cells[rr * SCREEN_COLS + rc];
                end
                MODE_CLEAR: blank_all();
                default: ;
            endcase
            a.col = cur_x[COL_W-1:0];
            a.row = cur_y[ROW_W-1:0];
            answers_due.push_back(a);
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            faults++;
            if (faults <= REPORT_CAP)
                $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        endfunction

        function void match_answer(t_answer got);
            t_answer want;
            if (answers_due.size() == 0) begin
                faults++;
                if (faults <= REPORT_CAP)
                    $display("%0t ns: result with nothing pending, expected none, got %p",
                             $time, got);
                return;
            end
            want = answers_due.pop_front();
            if (got.ch !== want.ch)   flag("cell_char", 32'(want.ch), 32'(got.ch));
            if (got.fg !== want.fg)   flag("cell_fg", 32'(want.fg), 32'(got.fg));
            if (got.bg !== want.bg)   flag("cell_bg", 32'(want.bg), 32'(got.bg));
            if (got.col !== want.col) flag("cursor_col", 32'(want.col), 32'(got.col));
            if (got.row !== want.row) flag("cursor_row", 32'(want.row), 32'(got.row));
            if (got.scr !== want.scr) flag("scrolled", 32'(want.scr), 32'(got.scr));
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [MODE_W-1:0]   i_mode;
    logic [CHAR_W-1:0]   i_char_code;
    logic [COL_W-1:0]    i_read_col;
    logic [ROW_W-1:0]    i_read_row;
    logic                o_done;
    logic [CHAR_W-1:0]   o_cell_char;
    logic [CLR_W-1:0]    o_cell_fg;
    logic [CLR_W-1:0]    o_cell_bg;
    logic [COL_W-1:0]    o_cursor_col;
    logic [ROW_W-1:0]    o_cursor_row;
    logic                o_scrolled;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    t_screen_shadow model = new();
    int             burst_left = 0;

    text_console_cursor_scroll DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_char_code  (i_char_code),
        .i_read_col   (i_read_col),
        .i_read_row   (i_read_row),
        .o_done       (o_done),
        .o_cell_char  (o_cell_char),
        .o_cell_fg    (o_cell_fg),
        .o_cell_bg    (o_cell_bg),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_scrolled   (o_scrolled),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Timeout, sized well beyond a worst case in which every command scrolls.
    initial begin
        #200_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result side: o_done marks a one-cycle result transfer, taken at the
    // edge that closes it. Sampled at the edge, so the values are pre-update.
    always @(posedge i_clk) begin : result_monitor
        t_answer seen;
        if (i_rst_n && o_done === 1'b1) begin
            seen = '{ch: o_cell_char, fg: o_cell_fg, bg: o_cell_bg, col: o_cursor_col,
                     row: o_cursor_row, scr: o_scrolled};
            model.match_answer(seen);
        end
    end

    // One command transfer. start is raised (or kept) here; the command is
    // taken at the first edge that sees busy low, and predicted right there.
    task automatic send_command(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] c,
                                input logic [COL_W-1:0] rc, input logic [ROW_W-1:0] rr);
        start       <= 1'b1;
        i_mode      <= m;
        i_char_code <= c;
        i_read_col  <= rc;
        i_read_row  <= rr;
        do @(posedge i_clk); while (busy !== 1'b0);
        model.apply_command(m, c, rc, rr);
    endtask

    // Drop start and hold until every owed result is in and the block is idle.
    // start only ever reads high right after an accept, so the extra edge
    // falls while the block is busy.
    task automatic settle();
        if (start !== 1'b0) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        while (model.answers_due.size() != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    // Command with sender pacing: bursts of random length, random gaps,
    // now and then a full drain, and some long stretches with no gaps.
    task automatic issue(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] c,
                         input logic [COL_W-1:0] rc, input logic [ROW_W-1:0] rr);
        send_command(m, c, rc, rr);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if ($urandom_range(0, 29) == 0) begin
                settle();
            end else begin
                start <= 1'b0;
                if ($urandom_range(0, 7) == 0) repeat ($urandom_range(10, 300)) @(posedge i_clk);
                else repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                       : $urandom_range(0, 12);
        end
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_transfer(input logic wr, input logic idx, input logic [CLR_W-1:0] val,
                                output logic [PDATA_W-1:0] rd);
        logic [PADDR_W-1:0] addr;
        addr          = '0;
        addr[REG_BIT] = idx;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= PDATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rd = prdata;
    endtask

    // Write both colors, reading each back. psel stays up between transfers.
    task automatic set_colors(input logic [CLR_W-1:0] f, input logic [CLR_W-1:0] b);
        logic [PDATA_W-1:0] back;
        apb_transfer(1'b1, REG_FG, f, back);
        model.fg = f;
        apb_transfer(1'b0, REG_FG, f, back);
        if (back !== PDATA_W'(f)) model.flag("foreground readback", PDATA_W'(f), back);
        apb_transfer(1'b1, REG_BG, b, back);
        model.bg = b;
        apb_transfer(1'b0, REG_BG, b, back);
        if (back !== PDATA_W'(b)) model.flag("background readback", PDATA_W'(b), back);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Reads: mostly the cursor row (fresh writes, scrolled rows), some
    // anywhere on screen, a few over the full field range.
    task automatic random_read();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            issue(MODE_READ, CHAR_W'($urandom), COL_W'($urandom_range(0, SCREEN_COLS - 1)),
                  ROW_W'(model.cur_y));
        else if (r < 9)
            issue(MODE_READ, CHAR_W'($urandom), COL_W'($urandom_range(0, SCREEN_COLS - 1)),
                  ROW_W'($urandom_range(0, SCREEN_ROWS - 1)));
        else
            issue(MODE_READ, CHAR_W'($urandom), COL_W'($urandom_range(0, 127)),
                  ROW_W'($urandom_range(0, 31)));
    endtask

    // Mostly text typed in lines, with enough line ends to reach the bottom
    // and keep scrolling; noise bytes and the spare mode are not counted.
    task automatic random_commands(input int quota);
        int taken;
        int k;
        int pick;
        taken = 0;
        while (taken < quota) begin
            pick = $urandom_range(0, 199);
            if (pick < 60) begin
                k = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 10);
                repeat (k) issue(MODE_PUT, CHAR_W'($urandom_range(CH_SPACE, CH_LAST)),
                                 COL_W'($urandom), ROW_W'($urandom));
                taken += k;
            end else if (pick < 120) begin
                if ($urandom_range(0, 1) == 1) begin
                    issue(MODE_PUT, CH_CR, COL_W'($urandom), ROW_W'($urandom));
                    taken++;
                end
                issue(MODE_PUT, CH_LF, COL_W'($urandom), ROW_W'($urandom));
                taken++;
            end else if (pick < 130) begin
                k = $urandom_range(1, 3);
                repeat (k) issue(MODE_PUT, CH_TAB, COL_W'($urandom), ROW_W'($urandom));
                taken += k;
            end else if (pick < 140) begin
                k = $urandom_range(1, 4);
                repeat (k) issue(MODE_PUT, CH_BS, COL_W'($urandom), ROW_W'($urandom));
                taken += k;
            end else if (pick < 180) begin
                k = $urandom_range(1, 4);
                repeat (k) random_read();
                taken += k;
            end else if (pick < 190) begin
                // any byte: high bytes and stray control codes do nothing
                issue(MODE_PUT, CHAR_W'($urandom_range(0, 255)), COL_W'($urandom),
                      ROW_W'($urandom));
            end else if (pick < 196) begin
                issue(MODE_SPARE, CHAR_W'($urandom), COL_W'($urandom), ROW_W'($urandom));
            end else if (pick == 199 && $urandom_range(0, 2) == 0) begin
                issue(MODE_CLEAR, CHAR_W'($urandom), COL_W'($urandom), ROW_W'($urandom));
                taken++;
            end else begin
                issue(MODE_READ, CHAR_W'($urandom), COL_W'($urandom_range(0, 127)),
                      ROW_W'($urandom_range(0, 31)));
                taken++;
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_mode      <= MODE_PUT;
        i_char_code <= '0;
        i_read_col  <= '0;
        i_read_row  <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // let the post-reset clearing pass finish before touching colors
        while (busy !== 1'b1) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        set_colors(FG_RESET, BG_RESET);

        // directed: read corners and out-of-range cells of the blank screen
        issue(MODE_READ, 8'h00, 7'd0, 5'd0);
        issue(MODE_READ, 8'h00, 7'd79, 5'd24);
        issue(MODE_READ, 8'hFF, 7'd127, 5'd31);
        issue(MODE_READ, 8'h00, 7'd80, 5'd0);
        issue(MODE_READ, 8'h00, 7'd0, 5'd25);
        // printable characters, both extremes among them, then ignored bytes (high half and stray controls)
        issue(MODE_PUT, 8'h41, 7'd0, 5'd0);
        issue(MODE_PUT, CH_LAST, 7'd0, 5'd0);
        issue(MODE_PUT, CH_SPACE, 7'd0, 5'd0);
        issue(MODE_PUT, 8'hFF, 7'd127, 5'd31);
        issue(MODE_PUT, 8'h80, 7'd0, 5'd0);
        issue(MODE_PUT, 8'h00, 7'd0, 5'd0);
        issue(MODE_PUT, 8'h1F, 7'd0, 5'd0);
        // backspace blanks the cell it steps back onto
        issue(MODE_PUT, CH_BS, 7'd0, 5'd0);
        issue(MODE_READ, 8'h00, 7'd2, 5'd0);
        issue(MODE_READ, 8'h00, 7'd0, 5'd0);
        // carriage return, then backspace at column 0 does nothing
        issue(MODE_PUT, CH_CR, 7'd0, 5'd0);
        issue(MODE_PUT, CH_BS, 7'd0, 5'd0);
        issue(MODE_PUT, CH_TAB, 7'd0, 5'd0);
        issue(MODE_PUT, CH_TAB, 7'd0, 5'd0);
        issue(MODE_PUT, CH_LF, 7'd0, 5'd0);
        issue(MODE_SPARE, 8'hFF, 7'd127, 5'd31);
        issue(MODE_READ, 8'h00, 7'd1, 5'd0);
        issue(MODE_CLEAR, 8'h00, 7'd0, 5'd0);
        issue(MODE_READ, 8'h00, 7'd0, 5'd0);

        // random phases, colors changed only with nothing in flight
        for (int p = 0; p < 5; p++) begin
            settle();
            case (p)
                0: set_colors(4'd0, 4'd15);
                1: set_colors(4'd15, 4'd0);
                3: set_colors(4'd0, 4'd0);
                default: set_colors(CLR_W'($urandom_range(0, 15)),
                                    CLR_W'($urandom_range(0, 15)));
            endcase
            random_commands(106);
        end

        settle();
        repeat (16) @(posedge i_clk);
        if (model.faults == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
